// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define CRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/crc_pkg.sv =====
`default_nettype none
package crc_pkg;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int S_DATA_W   = 128;
  localparam int M_DATA_W   = 104;
  localparam int KIND_W     = 3;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] REG_BACKOFF     = 2'd2;
  localparam logic [1:0] REG_REJECT_CODE = 2'd3;

  // input event kinds
  localparam logic [2:0] CMD_SUBMIT = 3'd0;
  localparam logic [2:0] CMD_POLL   = 3'd1;
  localparam logic [2:0] CMD_SENT   = 3'd2;
  localparam logic [2:0] CMD_AIRED  = 3'd3;
  localparam logic [2:0] CMD_ACK    = 3'd4;

  // result actions
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_SEND     = 3'd1;
  localparam logic [2:0] ACT_RESOLVE  = 3'd2;
  localparam logic [2:0] ACT_ACCEPTED = 3'd3;
  localparam logic [2:0] ACT_BUSY     = 3'd4;

  // resolve outcomes
  localparam logic [1:0] OUTC_ACKED     = 2'd0;
  localparam logic [1:0] OUTC_NO_ACK    = 2'd1;
  localparam logic [1:0] OUTC_RESYNC_NG = 2'd2;

  // sequence number restarted after a context resync
  localparam logic [15:0] SEQ_RESYNC = 16'd1;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SEND_DUE = 2'd1,
    PH_AWAIT    = 2'd2,
    PH_RESOLVED = 2'd3
  } phase_t;

  typedef struct packed {
    logic [31:0] ack_timeout_ms;
    logic [3:0]  retry_limit;
    logic [31:0] retry_backoff_ms;
    logic [7:0]  rejected_ctx_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] now_ms;
    logic [7:0]  dst;
    logic [7:0]  command_code;
    logic [15:0] arg_one;
    logic [15:0] arg_two;
    logic [7:0]  ctx_id;
    logic [15:0] seq;
    logic [7:0]  ack_result;
    logic [15:0] ack_detail;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  out_dst;
    logic [7:0]  out_command;
    logic [15:0] out_arg_one;
    logic [15:0] out_arg_two;
    logic [15:0] out_seq;
    logic [7:0]  out_ctx;
    logic [3:0]  out_attempt;
    logic        ctx_resynced;
    logic [1:0]  outcome;
    logic [7:0]  out_result;
    logic [15:0] out_detail;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/crc_cfg_regs.sv =====
`default_nettype none
module crc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [crc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [crc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output crc_pkg::cfg_t                   cfg
);
  import crc_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ACK_TIMEOUT: cfg.ack_timeout_ms    <= pwdata;
        REG_RETRY_LIMIT: cfg.retry_limit       <= pwdata[3:0];
        REG_BACKOFF:     cfg.retry_backoff_ms  <= pwdata;
        REG_REJECT_CODE: cfg.rejected_ctx_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ACK_TIMEOUT: prdata = cfg.ack_timeout_ms;
      REG_RETRY_LIMIT: prdata = {28'd0, cfg.retry_limit};
      REG_BACKOFF:     prdata = cfg.retry_backoff_ms;
      REG_REJECT_CODE: prdata = {24'd0, cfg.rejected_ctx_code};
      default:         prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/crc_engine.sv =====
`default_nettype none
`include "assert_macros.svh"
module crc_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  crc_pkg::in_item_t item,
  input  crc_pkg::cfg_t     cfg,
  output crc_pkg::res_t     res
);
  import crc_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  held_dst, held_dst_next;
  logic [7:0]  held_command, held_command_next;
  logic [15:0] held_arg_one, held_arg_one_next;
  logic [15:0] held_arg_two, held_arg_two_next;
  logic [7:0]  held_ctx, held_ctx_next;
  logic [15:0] held_seq, held_seq_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic        resync_spent, resync_spent_next;
  logic        adopted_flag, adopted_flag_next;
  logic [1:0]  final_outcome, final_outcome_next;
  logic [7:0]  final_result, final_result_next;
  logic [15:0] final_detail, final_detail_next;
  logic [31:0] window_start_ms, window_start_ms_next;

  logic [31:0] elapsed;
  logic [31:0] window;
  logic        window_open;
  logic        retries_out;
  logic        ack_match;
  logic        ack_rejected;

  // wrap-safe window test, both sides read as signed 32-bit
  assign elapsed      = item.now_ms - window_start_ms;
  assign window       = cfg.ack_timeout_ms +
                        ((attempt_count != 4'd0) ? cfg.retry_backoff_ms : 32'd0);
  assign window_open  = $signed(elapsed) < $signed(window);
  assign retries_out  = attempt_count >= cfg.retry_limit;
  assign ack_match    = (phase == PH_AWAIT) && (item.dst == held_dst) &&
                        (item.seq == held_seq);
  assign ack_rejected = item.ack_result == cfg.rejected_ctx_code;

  // next state
  always_comb begin
    phase_next           = phase;
    held_dst_next        = held_dst;
    held_command_next    = held_command;
    held_arg_one_next    = held_arg_one;
    held_arg_two_next    = held_arg_two;
    held_ctx_next        = held_ctx;
    held_seq_next        = held_seq;
    attempt_count_next   = attempt_count;
    resync_spent_next    = resync_spent;
    adopted_flag_next    = adopted_flag;
    final_outcome_next   = final_outcome;
    final_result_next    = final_result;
    final_detail_next    = final_detail;
    window_start_ms_next = window_start_ms;
    case (item.cmd)
      CMD_SUBMIT: begin
        if (phase == PH_IDLE) begin
          held_dst_next        = item.dst;
          held_command_next    = item.command_code;
          held_arg_one_next    = item.arg_one;
          held_arg_two_next    = item.arg_two;
          held_ctx_next        = item.ctx_id;
          held_seq_next        = item.seq;
          attempt_count_next   = 4'd0;
          resync_spent_next    = 1'b0;
          adopted_flag_next    = 1'b0;
          final_outcome_next   = OUTC_ACKED;
          final_result_next    = 8'd0;
          final_detail_next    = 16'd0;
          window_start_ms_next = item.now_ms;
          phase_next           = PH_SEND_DUE;
        end
      end
      CMD_POLL: begin
        case (phase)
          PH_AWAIT: begin
            if (!window_open) begin
              if (retries_out) begin
                // resolved and reported by this same poll
                final_outcome_next = OUTC_NO_ACK;
                phase_next         = PH_IDLE;
              end else begin
                attempt_count_next = attempt_count + 4'd1;
                phase_next         = PH_SEND_DUE;
              end
            end
          end
          PH_RESOLVED: phase_next = PH_IDLE;
          default: ;
        endcase
      end
      CMD_SENT: begin
        if (phase == PH_SEND_DUE) begin
          window_start_ms_next = item.now_ms;
          adopted_flag_next    = 1'b0;
          phase_next           = PH_AWAIT;
        end
      end
      CMD_AIRED: begin
        if (phase == PH_AWAIT) begin
          window_start_ms_next = item.now_ms;
        end
      end
      CMD_ACK: begin
        if (ack_match) begin
          if (ack_rejected && !resync_spent) begin
            // first context rejection: adopt and start over
            held_ctx_next        = item.ctx_id;
            held_seq_next        = SEQ_RESYNC;
            attempt_count_next   = 4'd0;
            resync_spent_next    = 1'b1;
            adopted_flag_next    = 1'b1;
            window_start_ms_next = item.now_ms;
            phase_next           = PH_SEND_DUE;
          end else begin
            final_outcome_next = ack_rejected ? OUTC_RESYNC_NG : OUTC_ACKED;
            final_result_next  = item.ack_result;
            final_detail_next  = item.ack_detail;
            phase_next         = PH_RESOLVED;
          end
        end
      end
      default: ;
    endcase
  end

  // result word
  always_comb begin
    logic do_send;
    logic do_resolve;
    do_send    = 1'b0;
    do_resolve = 1'b0;
    res        = '0;
    case (item.cmd)
      CMD_SUBMIT: res.action = (phase == PH_IDLE) ? ACT_ACCEPTED : ACT_BUSY;
      CMD_POLL: begin
        case (phase)
          PH_SEND_DUE: do_send    = 1'b1;
          PH_RESOLVED: do_resolve = 1'b1;
          PH_AWAIT: begin
            do_send    = !window_open && !retries_out;
            do_resolve = !window_open && retries_out;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (do_send) begin
      res.action       = ACT_SEND;
      res.out_dst      = held_dst;
      res.out_command  = held_command;
      res.out_arg_one  = held_arg_one;
      res.out_arg_two  = held_arg_two;
      res.out_seq      = held_seq;
      res.out_ctx      = held_ctx;
      res.out_attempt  = attempt_count_next;
      res.ctx_resynced = adopted_flag;
    end else if (do_resolve) begin
      res.action      = ACT_RESOLVE;
      res.out_dst     = held_dst;
      res.out_seq     = held_seq;
      res.out_attempt = attempt_count;
      res.outcome     = final_outcome_next;
      res.out_result  = final_result;
      res.out_detail  = final_detail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      held_dst        <= '0;
      held_command    <= '0;
      held_arg_one    <= '0;
      held_arg_two    <= '0;
      held_ctx        <= '0;
      held_seq        <= '0;
      attempt_count   <= '0;
      resync_spent    <= 1'b0;
      adopted_flag    <= 1'b0;
      final_outcome   <= OUTC_ACKED;
      final_result    <= '0;
      final_detail    <= '0;
      window_start_ms <= '0;
    end else if (fire) begin
      phase           <= phase_next;
      held_dst        <= held_dst_next;
      held_command    <= held_command_next;
      held_arg_one    <= held_arg_one_next;
      held_arg_two    <= held_arg_two_next;
      held_ctx        <= held_ctx_next;
      held_seq        <= held_seq_next;
      attempt_count   <= attempt_count_next;
      resync_spent    <= resync_spent_next;
      adopted_flag    <= adopted_flag_next;
      final_outcome   <= final_outcome_next;
      final_result    <= final_result_next;
      final_detail    <= final_detail_next;
      window_start_ms <= window_start_ms_next;
    end
  end

  `CRC_ASSERT_IMP(a_adopt_needs_resync, adopted_flag, resync_spent)
  `CRC_ASSERT_NXT(a_resolve_goes_idle, fire && (res.action == ACT_RESOLVE), phase == PH_IDLE)
  `CRC_ASSERT_IMP(a_idle_no_traffic, fire && (phase == PH_IDLE),
                  (res.action != ACT_SEND) && (res.action != ACT_RESOLVE))

endmodule
`default_nettype wire

// ===== hw/rtl/crc_out_skid.sv =====
`default_nettype none
`include "assert_macros.svh"
module crc_out_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  crc_pkg::res_t push_data,
  output logic          can_take,
  output logic          m_valid,
  input  logic          m_ready,
  output crc_pkg::res_t m_data
);
  import crc_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic pop;

  assign pop      = m_valid & m_ready;
  assign can_take = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!m_valid || pop) begin
        m_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_valid <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        m_data <= skid_data;
      end
    end else if (push) begin
      if (!m_valid || pop) begin
        m_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

  `CRC_ASSERT_IMP(a_skid_behind_main, skid_valid, m_valid)
  `CRC_ASSERT_NXT(a_skid_holds, skid_valid && !m_ready, skid_valid)
  `CRC_ASSERT_NXT(a_main_holds, m_valid && !m_ready, m_valid)

endmodule
`default_nettype wire

// ===== hw/rtl/command_retry_controller.sv =====
// Stop-and-wait command engine with retry and a single context resync.
// Input stream (s_*): one event word per handshake; s_tuser carries the event
// kind (submit, poll, sent, aired, ack), s_tdata the time stamp and fields.
// Output stream (m_*): exactly one result word per event word, in order;
// m_tuser is the action (none, send, resolve, accepted, busy).
// APB port: four 32-bit registers at byte offsets 0, 4, 8, 12 (ack timeout,
// retry limit, retry backoff, rejected-context code); pready is tied high.
// Write them only while no event is in flight.
// A result word passes through the input register, then the output skid stage,
// which drives m_tvalid. Throughput: one word per cycle while the skid has room,
// set by the state update (window add, signed compare) between input register and skid.
// Stalls: a two-entry output skid keeps s_tready high for one more word after
// m_tready drops; after that s_tready falls and nothing is lost.
// Reset (rst, synchronous, active high): engine idle, engine and config registers
// zero, input register and output skid empty; payload registers are not reset.
`default_nettype none
module command_retry_controller (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [31:0] now_ms, [39:32] dst, [47:40] command_code, [63:48] arg_one,
  // [79:64] arg_two, [87:80] ctx_id, [103:88] seq, [111:104] ack_result,
  // [127:112] ack_detail
  input  logic [crc_pkg::S_DATA_W-1:0]    s_tdata,
  // [2:0] cmd
  input  logic [crc_pkg::KIND_W-1:0]      s_tuser,
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] out_dst, [15:8] out_command, [31:16] out_arg_one, [47:32] out_arg_two,
  // [63:48] out_seq, [71:64] out_ctx, [75:72] out_attempt, [76] ctx_resynced,
  // [78:77] outcome, [86:79] out_result, [102:87] out_detail, [103] zero
  output logic [crc_pkg::M_DATA_W-1:0]    m_tdata,
  // [2:0] action
  output logic [crc_pkg::KIND_W-1:0]      m_tuser,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [crc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [crc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [crc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import crc_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  logic     in_valid;
  logic     fire;
  logic     can_take;
  res_t     eng_res;
  res_t     out_res;

  crc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // input register: the engine consumes it whenever the skid has room
  assign fire     = in_valid & can_take;
  assign s_tready = ~in_valid | can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.cmd          <= s_tuser;
      in_item.now_ms       <= s_tdata[31:0];
      in_item.dst          <= s_tdata[39:32];
      in_item.command_code <= s_tdata[47:40];
      in_item.arg_one      <= s_tdata[63:48];
      in_item.arg_two      <= s_tdata[79:64];
      in_item.ctx_id       <= s_tdata[87:80];
      in_item.seq          <= s_tdata[103:88];
      in_item.ack_result   <= s_tdata[111:104];
      in_item.ack_detail   <= s_tdata[127:112];
    end
  end

  crc_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_item),
    .cfg  (cfg),
    .res  (eng_res)
  );

  crc_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (eng_res),
    .can_take  (can_take),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_data    (out_res)
  );

  assign m_tuser = out_res.action;
  assign m_tdata = {1'b0, out_res.out_detail, out_res.out_result, out_res.outcome,
                    out_res.ctx_resynced, out_res.out_attempt, out_res.out_ctx,
                    out_res.out_seq, out_res.out_arg_two, out_res.out_arg_one,
                    out_res.out_command, out_res.out_dst};

endmodule
`default_nettype wire

// ===== tb/crc_tb_pkg.sv =====
`timescale 1ns / 1ps
package crc_tb_pkg;
  import crc_pkg::*;

  // Tracks the engine state word by word and keeps the result words it owes.
  class retry_tracker;
    logic [31:0] ack_timeout;
    logic [3:0]  retry_limit;
    logic [31:0] backoff;
    logic [7:0]  reject_code;

    phase_t      phase;
    logic [7:0]  held_dst;
    logic [7:0]  held_command;
    logic [15:0] held_arg_one;
    logic [15:0] held_arg_two;
    logic [7:0]  held_ctx;
    logic [15:0] held_seq;
    logic [3:0]  attempts;
    logic        resync_spent;
    logic        adopted;
    logic [1:0]  final_outcome;
    logic [7:0]  final_result;
    logic [15:0] final_detail;
    logic [31:0] window_start;

    res_t pending_results[$];

    int fail_count;
    int words_checked;
    int events_seen;
    int sends;
    int acked;
    int no_acks;
    int resync_fails;
    int resyncs;

    function new();
      ack_timeout   = '0;
      retry_limit   = '0;
      backoff       = '0;
      reject_code   = '0;
      phase         = PH_IDLE;
      held_dst      = '0;
      held_command  = '0;
      held_arg_one  = '0;
      held_arg_two  = '0;
      held_ctx      = '0;
      held_seq      = '0;
      attempts      = '0;
      resync_spent  = 1'b0;
      adopted       = 1'b0;
      final_outcome = '0;
      final_result  = '0;
      final_detail  = '0;
      window_start  = '0;
      fail_count    = 0;
      words_checked = 0;
      events_seen   = 0;
      sends         = 0;
      acked         = 0;
      no_acks       = 0;
      resync_fails  = 0;
      resyncs       = 0;
    endfunction

    function void write_cfg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_ACK_TIMEOUT: ack_timeout = v;
        REG_RETRY_LIMIT: retry_limit = v[3:0];
        REG_BACKOFF:     backoff = v;
        REG_REJECT_CODE: reject_code = v[7:0];
        default: ;
      endcase
    endfunction

    // Every retry (attempts above zero) gets the backoff on top; wraps mod 2^32.
    function logic [31:0] window_len();
      return ack_timeout + ((attempts != 4'd0) ? backoff : 32'd0);
    endfunction

    function res_t send_word();
      res_t r;
      r = '0;
      r.action       = ACT_SEND;
      r.out_dst      = held_dst;
      r.out_command  = held_command;
      r.out_arg_one  = held_arg_one;
      r.out_arg_two  = held_arg_two;
      r.out_seq      = held_seq;
      r.out_ctx      = held_ctx;
      r.out_attempt  = attempts;
      r.ctx_resynced = adopted;
      return r;
    endfunction

    function res_t resolve_word();
      res_t r;
      r = '0;
      r.action      = ACT_RESOLVE;
      r.out_dst     = held_dst;
      r.out_seq     = held_seq;
      r.out_attempt = attempts;
      r.outcome     = final_outcome;
      r.out_result  = final_result;
      r.out_detail  = final_detail;
      phase = PH_IDLE;
      return r;
    endfunction

    // Advances the engine by one accepted event word and queues its result.
    // Returns 1 when the word did something (not merely ignored).
    function bit note_event(in_item_t ev);
      res_t        r;
      phase_t      old_phase;
      logic [31:0] old_start;
      logic [31:0] diff;
      r = '0;
      old_phase = phase;
      old_start = window_start;
      case (ev.cmd)
        CMD_SUBMIT: begin
          if (phase != PH_IDLE) begin
            r.action = ACT_BUSY;
          end else begin
            held_dst      = ev.dst;
            held_command  = ev.command_code;
            held_arg_one  = ev.arg_one;
            held_arg_two  = ev.arg_two;
            held_ctx      = ev.ctx_id;
            held_seq      = ev.seq;
            attempts      = '0;
            resync_spent  = 1'b0;
            adopted       = 1'b0;
            final_outcome = '0;
            final_result  = '0;
            final_detail  = '0;
            window_start  = ev.now_ms;
            phase         = PH_SEND_DUE;
            r.action      = ACT_ACCEPTED;
          end
        end
        CMD_POLL: begin
          if (phase == PH_AWAIT) begin
            diff = ev.now_ms - window_start;
            if (!($signed(diff) < $signed(window_len()))) begin
              if (attempts >= retry_limit) begin
                final_outcome = OUTC_NO_ACK;
                phase = PH_RESOLVED;
              end else begin
                attempts = attempts + 4'd1;
                phase = PH_SEND_DUE;
              end
            end
          end
          if (phase == PH_SEND_DUE) r = send_word();
          else if (phase == PH_RESOLVED) r = resolve_word();
        end
        CMD_SENT: begin
          if (phase == PH_SEND_DUE) begin
            window_start = ev.now_ms;
            phase = PH_AWAIT;
            adopted = 1'b0;
          end
        end
        CMD_AIRED: begin
          if (phase == PH_AWAIT) window_start = ev.now_ms;
        end
        CMD_ACK: begin
          if (phase == PH_AWAIT && ev.dst == held_dst && ev.seq == held_seq) begin
            if (ev.ack_result == reject_code && !resync_spent) begin
              held_ctx     = ev.ctx_id;
              held_seq     = SEQ_RESYNC;
              attempts     = '0;
              resync_spent = 1'b1;
              adopted      = 1'b1;
              window_start = ev.now_ms;
              phase        = PH_SEND_DUE;
              resyncs++;
            end else begin
              final_outcome = (ev.ack_result == reject_code) ? OUTC_RESYNC_NG : OUTC_ACKED;
              final_result  = ev.ack_result;
              final_detail  = ev.ack_detail;
              phase         = PH_RESOLVED;
            end
          end
        end
        default: ;
      endcase
      pending_results.push_back(r);
      events_seen++;
      return (r.action != ACT_NONE) || (phase != old_phase) || (window_start != old_start);
    endfunction

    function void field_check(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, e, a);
        fail_count++;
      end
    endfunction

    function void check_word(logic [2:0] act, logic [103:0] d);
      res_t want;
      if (pending_results.size() == 0) begin
        $error("result word (action %0d) with no event waiting", act);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      field_check("action",       32'(want.action),       32'(act));
      field_check("out_dst",      32'(want.out_dst),      32'(d[7:0]));
      field_check("out_command",  32'(want.out_command),  32'(d[15:8]));
      field_check("out_arg_one",  32'(want.out_arg_one),  32'(d[31:16]));
      field_check("out_arg_two",  32'(want.out_arg_two),  32'(d[47:32]));
      field_check("out_seq",      32'(want.out_seq),      32'(d[63:48]));
      field_check("out_ctx",      32'(want.out_ctx),      32'(d[71:64]));
      field_check("out_attempt",  32'(want.out_attempt),  32'(d[75:72]));
      field_check("ctx_resynced", 32'(want.ctx_resynced), 32'(d[76]));
      field_check("outcome",      32'(want.outcome),      32'(d[78:77]));
      field_check("out_result",   32'(want.out_result),   32'(d[86:79]));
      field_check("out_detail",   32'(want.out_detail),   32'(d[102:87]));
      field_check("pad",          32'd0,                  32'(d[103]));
      words_checked++;
      if (act == ACT_SEND) sends++;
      if (act == ACT_RESOLVE) begin
        if (d[78:77] == OUTC_ACKED) acked++;
        else if (d[78:77] == OUTC_NO_ACK) no_acks++;
        else if (d[78:77] == OUTC_RESYNC_NG) resync_fails++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_command_retry_controller.sv =====
`timescale 1ns / 1ps
// Drives event words into the retry engine, predicts every result word with
// retry_tracker and checks them in order. Stimulus: a directed walk through
// the phases (wrong-phase events, wrap-around window, retry, no-ack, context
// resync and its second rejection), then random, mostly well-formed command
// lifecycles under several register settings.
module tb_command_retry_controller;
  import crc_pkg::*;
  import crc_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PER_SETTING = 390;
  // event kinds the engine does not decode
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  command_retry_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  retry_tracker tracker;

  int burst_left = 0;     // words left in the current sender burst
  int ack_weight = 20;    // percent of awaiting-phase words that are matching acks
  int settings_done = 0;
  int cycle_count = 0;
  int rdy_run = 0;        // receiver: cycles left in the current pattern
  int rdy_mode = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: runs of always-ready, random ready and solid stalls, so the
  // skid stage fills and s_tready drops now and then.
  always @(posedge clk) begin
    if (rdy_run == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_run = $urandom_range(1, (rdy_mode == 2) ? 12 : 40);
    end else begin
      rdy_run = rdy_run - 1;
    end
    case (rdy_mode)
      1:       m_tready <= ($urandom_range(0, 99) < 60);
      2:       m_tready <= 1'b0;
      default: m_tready <= 1'b1;
    endcase
  end

  // Output monitor: values seen here are the ones present before the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_word(m_tuser, m_tdata);
  end

  // One event word: optional gap first (bursty sender), then hold tvalid until
  // the word is taken. Called right after the clock rises.
  task automatic send_event(input in_item_t ev);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // every eighth burst or so is a long back-to-back stretch
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= ev.cmd;
    s_tdata  <= {ev.ack_detail, ev.ack_result, ev.seq, ev.ctx_id, ev.arg_two,
                 ev.arg_one, ev.command_code, ev.dst, ev.now_ms};
    do @(posedge clk); while (!s_tready);
    void'(tracker.note_event(ev));
  endtask

  task automatic ev_put(input logic [2:0] cmd, input logic [31:0] now,
                        input logic [7:0] dst, input logic [7:0] code,
                        input logic [15:0] a1, input logic [15:0] a2,
                        input logic [7:0] ctx, input logic [15:0] seq,
                        input logic [7:0] res, input logic [15:0] det);
    in_item_t ev;
    ev.cmd = cmd;
    ev.now_ms = now;
    ev.dst = dst;
    ev.command_code = code;
    ev.arg_one = a1;
    ev.arg_two = a2;
    ev.ctx_id = ctx;
    ev.seq = seq;
    ev.ack_result = res;
    ev.ack_detail = det;
    send_event(ev);
  endtask

  // Sender stops until every owed result word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then the bus returns to idle.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    tracker.write_cfg(idx, v);
  endtask

  task automatic set_config(input logic [31:0] t, input logic [3:0] l,
                            input logic [31:0] b, input logic [7:0] r);
    wait_drained();
    apb_write(REG_ACK_TIMEOUT, t);
    apb_write(REG_RETRY_LIMIT, {28'd0, l});
    apb_write(REG_BACKOFF, b);
    apb_write(REG_REJECT_CODE, {24'd0, r});
    settings_done++;
  endtask

  // Time stamps cluster on the window edge so both sides of the signed
  // compare get hit; some are far off or before the window start.
  function automatic logic [31:0] pick_time();
    logic [31:0] w;
    logic [31:0] t;
    w = tracker.window_len();
    case ($urandom_range(0, 5))
      0:       t = tracker.window_start + w - 32'd1;
      1:       t = tracker.window_start + w;
      2:       t = tracker.window_start + $urandom_range(0, 300);
      3:       t = $urandom;
      4:       t = tracker.window_start - $urandom_range(1, 300);
      default: t = tracker.window_start + w + $urandom_range(1, 50);
    endcase
    return t;
  endfunction

  // Next random word, shaped by the predicted phase so most words move a
  // command through its lifecycle; the rest is noise.
  function automatic in_item_t make_event();
    in_item_t ev;
    int       pick;
    ev.cmd          = 3'($urandom_range(0, 7));
    ev.now_ms       = $urandom;
    ev.dst          = 8'($urandom_range(0, 255));
    ev.command_code = 8'($urandom_range(0, 255));
    ev.arg_one      = 16'($urandom_range(0, 65535));
    ev.arg_two      = 16'($urandom_range(0, 65535));
    ev.ctx_id       = 8'($urandom_range(0, 255));
    ev.seq          = 16'($urandom_range(0, 65535));
    ev.ack_result   = 8'($urandom_range(0, 255));
    ev.ack_detail   = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    case (tracker.phase)
      PH_IDLE: begin
        if (pick < 85) begin
          ev.cmd = CMD_SUBMIT;
          ev.now_ms = pick_time();
        end
      end
      PH_SEND_DUE: begin
        if (pick < 45) begin
          ev.cmd = CMD_POLL;
          ev.now_ms = pick_time();
        end else if (pick < 85) begin
          ev.cmd = CMD_SENT;
          ev.now_ms = pick_time();
        end
      end
      PH_AWAIT: begin
        if (pick < 55) begin
          ev.cmd = CMD_POLL;
          ev.now_ms = pick_time();
        end else if (pick < 65) begin
          ev.cmd = CMD_AIRED;
          ev.now_ms = pick_time();
        end else if (pick < 65 + ack_weight) begin
          ev.cmd = CMD_ACK;
          ev.dst = tracker.held_dst;
          ev.seq = tracker.held_seq;
          if ($urandom_range(0, 99) < 35) ev.ack_result = tracker.reject_code;
        end else if (pick < 80 + ack_weight) begin
          // ack that misses on exactly one of destination or sequence
          ev.cmd = CMD_ACK;
          ev.dst = tracker.held_dst;
          ev.seq = tracker.held_seq;
          if ($urandom_range(0, 1) == 0) ev.dst = ev.dst ^ (8'd1 << $urandom_range(0, 7));
          else ev.seq = ev.seq ^ (16'd1 << $urandom_range(0, 15));
        end
      end
      default: begin
        if (pick < 85) begin
          ev.cmd = CMD_POLL;
          ev.now_ms = pick_time();
        end
      end
    endcase
    return ev;
  endfunction

  // Sends a fixed number of random words.
  task automatic run_random(input int target);
    int       done;
    in_item_t ev;
    done = 0;
    while (done < target) begin
      ev = make_event();
      send_event(ev);
      done++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk: timeout 100, one retry, backoff 50, reject code 0xEE.
    set_config(32'd100, 4'd1, 32'd50, 8'hEE);
    // events with nothing in flight, and undecoded kinds
    ev_put(CMD_POLL,      32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_SENT,      32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_AIRED,     32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_ACK,       32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_UNUSED_LO, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF,
           8'hFF, 16'hFFFF);
    ev_put(CMD_UNUSED_HI, 32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    // all-ones command (arg_two zero) just before the time stamp wraps; second submit is busy
    ev_put(CMD_SUBMIT, 32'hFFFF_FFF0, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF, 16'hFFFF,
           8'h00, 16'h0000);
    ev_put(CMD_SUBMIT, 32'd5, 8'h12, 8'h34, 16'h5678, 16'h9ABC, 8'hDE, 16'h0001, 8'h00, 16'h0000);
    ev_put(CMD_POLL,   32'hFFFF_FFF0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_SENT,   32'hFFFF_FFF0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    // acks missing on destination, then on sequence
    ev_put(CMD_ACK,    32'd0, 8'hFE, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'hFFFF, 8'h00, 16'h0000);
    ev_put(CMD_ACK,    32'd0, 8'hFF, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'hFFFE, 8'h00, 16'h0000);
    // window across the wrap: 96 ms in is still open, 100 ms expires -> retry
    ev_put(CMD_POLL,   32'h0000_0050, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_POLL,   32'h0000_0054, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    // retry window is 150 ms from the airing time; then retries are used up
    ev_put(CMD_SENT,   32'h0000_0100, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_AIRED,  32'h0000_0200, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_POLL,   32'h0000_0295, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_POLL,   32'h0000_0296, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    // rejected context: first one adopts the new context, second one fails
    ev_put(CMD_SUBMIT, 32'd0, 8'h00, 8'h00, 16'h0000, 16'hFFFF, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_POLL,   32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_SENT,   32'd0, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_ACK,    32'd7, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h5A, 16'h0000, 8'hEE, 16'h1234);
    ev_put(CMD_POLL,   32'd8, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_SENT,   32'd9, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);
    ev_put(CMD_ACK,    32'd10, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'hA5, 16'h0001, 8'hEE, 16'hFFFF);
    ev_put(CMD_POLL,   32'd11, 8'h00, 8'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000);

    // Random lifecycles under each setting; the registers change only with
    // the output drained (set_config waits for that).
    ack_weight = 20;
    set_config(32'd100, 4'd3, 32'd50, 8'hEE);
    run_random(RANDOM_PER_SETTING);

    // all zero: every poll in the awaiting phase expires unless time runs back
    ack_weight = 30;
    set_config(32'd0, 4'd0, 32'd0, 8'h00);
    run_random(RANDOM_PER_SETTING);

    // all ones: window reads as -1 / -2; few acks so retries reach the limit
    ack_weight = 5;
    set_config(32'hFFFF_FFFF, 4'd15, 32'hFFFF_FFFF, 8'hFF);
    run_random(RANDOM_PER_SETTING);

    // largest positive window, then backoff pushes it to the most negative
    ack_weight = 5;
    set_config(32'h7FFF_FFFF, 4'd15, 32'd1, 8'h80);
    run_random(RANDOM_PER_SETTING);

    ack_weight = 20;
    set_config($urandom_range(0, 400), 4'($urandom_range(0, 15)), $urandom_range(0, 200),
               8'($urandom_range(0, 255)));
    run_random(RANDOM_PER_SETTING);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d event words, %0d result words checked, %0d register settings.",
             tracker.events_seen, tracker.words_checked, settings_done);
    $display("Sends %0d; resolved acked %0d, no-ack %0d, resync-failed %0d; resyncs %0d.",
             tracker.sends, tracker.acked, tracker.no_acks, tracker.resync_fails,
             tracker.resyncs);
    if (tracker.fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
